### design/mbce_pkg.sv
package mbce_pkg;

  // Default screen geometry.
  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 240;

  // Pixels carried by one bitmap byte.
  localparam int BYTE_PIXELS = 8;

  // Register reset values.
  localparam logic [7:0]  ORIGIN_X_RST = 8'd0;
  localparam logic [7:0]  ORIGIN_Y_RST = 8'd0;
  localparam logic [7:0]  WIDTH_RST    = 8'd8;
  localparam logic [7:0]  HEIGHT_RST   = 8'd16;
  localparam logic [15:0] FORE_RST     = 16'hFFFF;
  localparam logic [15:0] BACK_RST     = 16'h0000;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_FORE     = 3'd4,
    REG_BACK     = 3'd5
  } reg_index_t;

  // Current register contents.
  typedef struct packed {
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [15:0] fore;
    logic [15:0] back;
  } cfg_t;

  // Work for one accepted byte, handed from the row tracker to the serializer.
  typedef struct packed {
    logic       ok;
    logic [7:0] bits;
    logic [3:0] count;
    logic       end_row;
    logic       end_map;
  } item_desc_t;

endpackage

### design/mbce_geom.sv
module mbce_geom import mbce_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] bitmap_byte,
  output item_desc_t desc
);

  // Sum width holds both origin plus width and the screen size.
  localparam int XW = $clog2(SCREEN_WIDTH + 512);
  localparam int YW = $clog2(SCREEN_HEIGHT + 512);

  logic [4:0] byte_in_row;
  logic [4:0] byte_in_row_next;
  logic [7:0] row_index;
  logic [7:0] row_index_next;

  logic [XW-1:0] x_end;
  logic [YW-1:0] y_end;
  logic          window_ok;
  logic [4:0]    last_byte;
  logic          end_row;
  logic          end_map;
  logic [7:0]    tail_pixels;

  // The window must be nonempty and lie fully on the screen.
  assign x_end = XW'(cfg.origin_x) + XW'(cfg.width);
  assign y_end = YW'(cfg.origin_y) + YW'(cfg.height);
  assign window_ok = (cfg.width != 8'd0) && (cfg.height != 8'd0) &&
                     (x_end <= XW'(SCREEN_WIDTH)) && (y_end <= YW'(SCREEN_HEIGHT));

  // Position of this byte within the bitmap.
  assign last_byte   = 5'((9'(cfg.width) + 9'd7) >> 3) - 5'd1;
  assign end_row     = byte_in_row >= last_byte;
  assign end_map     = end_row && (row_index >= cfg.height - 8'd1);
  assign tail_pixels = cfg.width - {last_byte, 3'b000};

  always_comb begin
    desc.ok      = window_ok;
    desc.bits    = bitmap_byte;
    desc.count   = end_row ? tail_pixels[3:0] : 4'(BYTE_PIXELS);
    desc.end_row = end_row;
    desc.end_map = end_map;
  end

  // Counters advance only on bytes of a valid window.
  always_comb begin
    byte_in_row_next = byte_in_row;
    row_index_next   = row_index;
    if (accept && window_ok) begin
      if (end_row) begin
        byte_in_row_next = 5'd0;
        row_index_next   = end_map ? 8'd0 : row_index + 8'd1;
      end else begin
        byte_in_row_next = byte_in_row + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row <= 5'd0;
      row_index   <= 8'd0;
    end else begin
      byte_in_row <= byte_in_row_next;
      row_index   <= row_index_next;
    end
  end

  // A byte at the last row and last byte closes the bitmap.
  a_map_is_row: assert property (@(posedge clk) disable iff (rst)
    end_map |-> end_row)
    else $error("bitmap end without row end");

  // After a closing byte both counters are back at zero.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && window_ok && end_map) |=> (byte_in_row == 5'd0 && row_index == 8'd0))
    else $error("counters did not wrap after bitmap end");

  // The final byte of a row never yields more than a full byte of pixels.
  a_tail: assert property (@(posedge clk) disable iff (rst)
    (window_ok && end_row) |-> (tail_pixels >= 8'd1 && tail_pixels <= 8'd8))
    else $error("row tail pixel count out of range");

endmodule

### design/mbce_serial.sv
module mbce_serial import mbce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        load,
  input  item_desc_t  desc,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_color,
  output logic        last_of_byte,
  output logic        last_of_row,
  output logic        last_of_bitmap
);

  // Holding register: the byte being expanded.
  logic       h_valid;
  logic [7:0] h_bits;
  logic [3:0] h_left;
  logic       h_end_row;
  logic       h_end_map;

  logic o_load;
  logic h_last;

  // One pixel moves to the result register whenever it is free or being taken.
  assign o_load = h_valid && (!out_valid || !out_stall);
  assign h_last = (h_left == 4'd1);
  assign take   = !h_valid || (o_load && h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (take) begin
      h_valid <= load;
    end else if (o_load && h_last) begin
      h_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load) begin
      h_bits    <= desc.bits;
      h_left    <= desc.count;
      h_end_row <= desc.end_row;
      h_end_map <= desc.end_map;
    end else if (o_load) begin
      h_bits <= h_bits >> 1;
      h_left <= h_left - 4'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      pixel_color    <= h_bits[0] ? cfg.fore : cfg.back;
      last_of_byte   <= h_last;
      last_of_row    <= h_last && h_end_row;
      last_of_bitmap <= h_last && h_end_map;
    end
  end

  // A busy holding register always has pixels left to send.
  a_left: assert property (@(posedge clk) disable iff (rst)
    h_valid |-> (h_left != 4'd0 && h_left <= 4'(BYTE_PIXELS)))
    else $error("holding register has no pixels left");

  // A new byte enters a busy holding register only as its last pixel leaves.
  a_overlap: assert property (@(posedge clk) disable iff (rst)
    (load && take && h_valid) |-> (o_load && h_last))
    else $error("byte loaded over an unfinished byte");

  // Row and bitmap ends are always byte ends.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!last_of_row || last_of_byte) && (!last_of_bitmap || last_of_row)))
    else $error("inconsistent end flags");

endmodule

### design/mono_bitmap_color_expander.sv
// Monochrome bitmap color expander, RGB565 output.
//
// Input channel: one bitmap byte per item (in_valid / in_stall), bit 0 is
// the leftmost pixel. Output channel: one pixel color per item
// (out_valid / out_stall) with byte, row and bitmap end flags.
// Configuration: cfg_valid / cfg_ready write port, always ready; cfg_index
// selects origin_x, origin_y, width, height, fore color, back color.
//
// An accepted byte enters the holding register, and its pixels move one at a
// time to the result register. A byte occupies the holding register until its
// last pixel leaves, and the last byte of a row yields only the pixels left in
// it. The single pixel path from holding register to result register limits
// the pixel rate. The next byte is accepted in the cycle its predecessor's last
// pixel leaves. Bytes for a window that is off screen or empty are consumed one
// per cycle once the holding register is empty and give no pixels.
//
// Reset clears the byte and row counters, empties the holding and result
// registers and loads the register defaults. On a receiver stall the result
// holds and the input stalls as soon as the holding register cannot drain.
module mono_bitmap_color_expander import mbce_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  bitmap_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_color,
  output logic        last_of_byte,
  output logic        last_of_row,
  output logic        last_of_bitmap
);

  cfg_t       cfg;
  item_desc_t desc;
  logic       take;
  logic       accept;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= ORIGIN_X_RST;
      cfg.origin_y <= ORIGIN_Y_RST;
      cfg.width    <= WIDTH_RST;
      cfg.height   <= HEIGHT_RST;
      cfg.fore     <= FORE_RST;
      cfg.back     <= BACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X: cfg.origin_x <= cfg_data[7:0];
        REG_ORIGIN_Y: cfg.origin_y <= cfg_data[7:0];
        REG_WIDTH:    cfg.width    <= cfg_data[7:0];
        REG_HEIGHT:   cfg.height   <= cfg_data[7:0];
        REG_FORE:     cfg.fore     <= cfg_data;
        REG_BACK:     cfg.back     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input handshake.
  assign in_stall = !take;
  assign accept   = in_valid && take;

  mbce_geom #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_geom (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .bitmap_byte (bitmap_byte),
    .desc        (desc)
  );

  mbce_serial u_serial (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .load           (accept && desc.ok),
    .desc           (desc),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_color    (pixel_color),
    .last_of_byte   (last_of_byte),
    .last_of_row    (last_of_row),
    .last_of_bitmap (last_of_bitmap)
  );

endmodule

### tb/mono_bitmap_color_expander_tb.sv
`timescale 1ns / 100ps

module mono_bitmap_color_expander_tb;
  import mbce_pkg::*;

  localparam int SCR_W = SCREEN_WIDTH_DEF;
  localparam int SCR_H = SCREEN_HEIGHT_DEF;
  localparam int MAX_GAP = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int TOTAL_ITEMS = 410;
  localparam int MAX_REPORTS = 100;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [15:0] color;
    logic        byte_end;
    logic        row_end;
    logic        map_end;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_ORIGIN_X;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  bitmap_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_color;
  logic        last_of_byte;
  logic        last_of_row;
  logic        last_of_bitmap;

  // Shadow copy of the registers and of the row/byte counters.
  logic [7:0]  win_x = ORIGIN_X_RST;
  logic [7:0]  win_y = ORIGIN_Y_RST;
  logic [7:0]  map_w = WIDTH_RST;
  logic [7:0]  map_h = HEIGHT_RST;
  logic [15:0] fg_color = FORE_RST;
  logic [15:0] bg_color = BACK_RST;
  logic [4:0]  byte_col = 5'd0;
  logic [7:0]  row_num = 8'd0;

  pixel_t pixel_q[$];
  int     failures = 0;
  int     sent_items = 0;
  bit     idle_en = 1'b1;
  int     hold_left = 0;
  bit     rx_taken = 1'b0;
  int     rx_wait = 0;

  mono_bitmap_color_expander DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .bitmap_byte(bitmap_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_color(pixel_color),
    .last_of_byte(last_of_byte),
    .last_of_row(last_of_row),
    .last_of_bitmap(last_of_bitmap)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expand one accepted byte into the pixels it should produce and advance
  // the shadow counters. An off-screen or empty window yields nothing.
  function automatic void expand_byte(input logic [7:0] bits);
    int     row_bytes;
    int     last_col;
    int     count;
    int     k;
    bit     end_row;
    bit     end_map;
    pixel_t px;
    if (map_w == 8'd0 || map_h == 8'd0) return;
    if (int'(win_x) + int'(map_w) - 1 >= SCR_W) return;
    if (int'(win_y) + int'(map_h) - 1 >= SCR_H) return;
    row_bytes = (int'(map_w) + 7) / 8;
    last_col = row_bytes - 1;
    // Counters left past the geometry by a register change close the row
    // or the bitmap on this byte.
    end_row = int'(byte_col) >= last_col;
    end_map = end_row && (int'(row_num) >= int'(map_h) - 1);
    count = end_row ? int'(map_w) - BYTE_PIXELS * last_col : BYTE_PIXELS;
    for (k = 0; k < count; k++) begin
      px.color = bits[k] ? fg_color : bg_color;
      px.byte_end = (k == count - 1);
      px.row_end = px.byte_end && end_row;
      px.map_end = px.byte_end && end_map;
      pixel_q.push_back(px);
    end
    if (end_row) begin
      byte_col = 5'd0;
      row_num = end_map ? 8'd0 : row_num + 8'd1;
    end else begin
      byte_col = byte_col + 5'd1;
    end
  endfunction

  // Offer one byte after a random gap and keep it until the block takes it.
  // Valid stays high on return so that a back-to-back byte needs no toggle.
  task automatic send_byte(input logic [7:0] bits);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    bitmap_byte <= bits;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    expand_byte(bits);
    sent_items++;
    @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    case (idx)
      REG_ORIGIN_X: win_x = data[7:0];
      REG_ORIGIN_Y: win_y = data[7:0];
      REG_WIDTH:    map_w = data[7:0];
      REG_HEIGHT:   map_h = data[7:0];
      REG_FORE:     fg_color = data;
      REG_BACK:     bg_color = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every expected pixel arrive and the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load a full window setup. The upper byte of narrow registers is random
  // since only the low byte must be kept.
  task automatic set_window(input logic [7:0] ox, input logic [7:0] oy,
                            input logic [7:0] w, input logic [7:0] h,
                            input logic [15:0] fg, input logic [15:0] bg);
    wait_idle();
    write_reg(REG_ORIGIN_X, {8'($urandom), ox});
    write_reg(REG_ORIGIN_Y, {8'($urandom), oy});
    write_reg(REG_WIDTH, {8'($urandom), w});
    write_reg(REG_HEIGHT, {8'($urandom), h});
    write_reg(REG_FORE, fg);
    write_reg(REG_BACK, bg);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    cfg_release();
  endtask

  function automatic logic [7:0] random_bits();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_color();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Check each pixel taken by the receiver against the oldest expectation.
  always @(negedge clk) begin : check_pixel
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      rx_taken = 1'b1;
      if (pixel_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected pixel: expected none, got color %h flags %b%b%b",
                   $time, pixel_color, last_of_byte, last_of_row, last_of_bitmap);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_color !== want.color) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: pixel_color expected %h got %h", $time, want.color, pixel_color);
        end
        if (last_of_byte !== want.byte_end) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: last_of_byte expected %b got %b", $time, want.byte_end,
                     last_of_byte);
        end
        if (last_of_row !== want.row_end) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: last_of_row expected %b got %b", $time, want.row_end, last_of_row);
        end
        if (last_of_bitmap !== want.map_end) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: last_of_bitmap expected %b got %b", $time, want.map_end,
                     last_of_bitmap);
        end
      end
    end
  end

  // Receiver: a random wait after each pixel, plus an optional long hold.
  always @(posedge clk) begin
    if (rx_taken) begin
      rx_taken = 1'b0;
      rx_wait = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    end
    out_stall <= (hold_left != 0) || (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  // The long receiver hold counts down here.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Reset values: solid patterns, single pixels at either edge, alternation.
  task automatic test_default_registers();
    logic [7:0] pattern[6] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  // Shrink the geometry while the counters sit past the new last byte and
  // last row; also check masking of wide data and ignored spare indexes.
  task automatic test_geometry_change();
    wait_idle();
    write_reg(REG_WIDTH, 16'hA518);
    cfg_release();
    send_byte(random_bits());
    send_byte(random_bits());
    wait_idle();
    write_reg(REG_WIDTH, 16'h5A09);
    write_reg(REG_HEIGHT, 16'hFF04);
    write_reg(REG_SPARE_LO, 16'h0001);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    cfg_release();
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_byte(8'h00);
  endtask

  // One-pixel bitmap in the bottom right corner with swapped extreme colors.
  task automatic test_corner_window();
    set_window(8'd239, 8'd239, 8'd1, 8'd1, 16'h0000, 16'hFFFF);
    send_byte(8'hFE);
    send_byte(8'h01);
  endtask

  // Windows that run off screen or are empty consume bytes silently.
  task automatic test_rejected_windows();
    set_window(8'd233, 8'd0, 8'd8, 8'd1, 16'h1234, 16'h4321);
    send_byte(8'hFF);
    send_byte(8'h00);
    set_window(8'd0, 8'd0, 8'd0, 8'd4, 16'h1234, 16'h4321);
    send_byte(8'hA5);
    set_window(8'd0, 8'd0, 8'd4, 8'd0, 16'h1234, 16'h4321);
    send_byte(8'h5A);
    set_window(8'd0, 8'd200, 8'd4, 8'd41, 16'h1234, 16'h4321);
    send_byte(8'h0F);
    set_window(8'd255, 8'd255, 8'd255, 8'd255, 16'h1234, 16'h4321);
    send_byte(8'hF0);
    // Counters must be where the last valid byte left them.
    set_window(8'd10, 8'd20, 8'd12, 8'd3, 16'hF800, 16'h07E0);
    repeat (3) send_byte(random_bits());
  endtask

  // Receiver holds off while bytes keep coming, so the input must stall.
  task automatic test_backpressure();
    set_window(8'd0, 8'd0, 8'd16, 8'd4, random_color(), random_color());
    idle_en = 1'b0;
    hold_left <= HOLD_CYCLES;
    repeat (24) send_byte(random_bits());
    wait_idle();
    idle_en = 1'b1;
  endtask

  // Sender pauses until the block has delivered everything, then resumes.
  task automatic test_sender_pause();
    repeat (2) begin
      repeat (6) send_byte(random_bits());
      wait_idle();
    end
  endtask

  // Random windows and bitmaps; most windows are valid and small.
  task automatic test_random_bitmaps();
    logic [7:0] ox, oy, w, h;
    int n;
    while (sent_items < TOTAL_ITEMS) begin
      n = $urandom_range(8, 40);
      case ($urandom_range(0, 9))
        0: begin
          w = 8'd240;
          ox = 8'd0;
          h = 8'($urandom_range(1, 3));
          oy = 8'($urandom_range(0, SCR_H - h));
          n = 64;
        end
        1: begin
          h = 8'd240;
          oy = 8'd0;
          w = 8'($urandom_range(1, 16));
          ox = 8'($urandom_range(0, SCR_W - w));
        end
        2: begin
          w = 8'd1;
          h = 8'd1;
          ox = 8'd239;
          oy = 8'd239;
        end
        3: begin
          w = 8'($urandom_range(0, 255));
          h = 8'($urandom_range(0, 255));
          ox = 8'($urandom_range(0, 255));
          oy = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 3))
            0: w = 8'd0;
            1: h = 8'd0;
            2: ox = (w > 8'd16) ? ox : 8'd240 + 8'($urandom_range(0, 15));
            default: w = 8'($urandom_range(241, 255));
          endcase
          n = 3;
        end
        default: begin
          w = 8'($urandom_range(1, 40));
          h = 8'($urandom_range(1, 6));
          ox = 8'($urandom_range(0, SCR_W - w));
          oy = 8'($urandom_range(0, SCR_H - h));
        end
      endcase
      if (n > TOTAL_ITEMS - sent_items) n = TOTAL_ITEMS - sent_items;
      set_window(ox, oy, w, h, random_color(), random_color());
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (n) send_byte(random_bits());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_registers();
    test_geometry_change();
    test_corner_window();
    test_rejected_windows();
    test_backpressure();
    test_sender_pause();
    test_random_bitmaps();
    wait_idle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #1200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
design/mbce_pkg.sv
design/mbce_geom.sv
design/mbce_serial.sv
design/mono_bitmap_color_expander.sv
tb/mono_bitmap_color_expander_tb.sv
